### rtl/cvpm_pkg.sv
package cvpm_pkg;

  // frame geometry
  localparam int unsigned CELLS = 15;
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CELLS - 1);

  // field widths
  localparam int unsigned CODE_W  = 14;
  localparam int unsigned GAIN_W  = 9;
  localparam int unsigned OFS_W   = 8;
  localparam int unsigned MV_W    = 16;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned EVT_W   = 8;
  localparam int unsigned PROD_W  = CODE_W + GAIN_W;
  localparam int unsigned QUOT_W  = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // divide by 1000 as multiply by ceil(2^33 / 1000), exact for products below 2^23
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam logic [RECIP_W-1:0] RECIP = 24'd8589935;
  localparam int unsigned SCALED_W    = PROD_W + RECIP_W;

  // saturation limits
  localparam logic [MV_W-1:0]  MV_MAX    = '1;
  localparam logic [SUM_W-1:0] SUM_MAX   = '1;
  localparam logic [EVT_W-1:0] EVENT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADC_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OV_THRESH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UV_THRESH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OV_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UV_LIMIT   = 3'd5;

  // register reset values
  localparam logic [GAIN_W-1:0]        GAIN_RST      = 9'd380;
  localparam logic signed [OFS_W-1:0]  OFFSET_RST    = 8'sd0;
  localparam logic [MV_W-1:0]          OV_THRESH_RST = 16'd4300;
  localparam logic [MV_W-1:0]          UV_THRESH_RST = 16'd2500;
  localparam logic [EVT_W-1:0]         OV_LIMIT_RST  = 8'd2;
  localparam logic [EVT_W-1:0]         UV_LIMIT_RST  = 8'd8;

  // limits used by the frame stage
  typedef struct packed {
    logic [MV_W-1:0]  ov_thresh;
    logic [MV_W-1:0]  uv_thresh;
    logic [EVT_W-1:0] ov_limit;
    logic [EVT_W-1:0] uv_limit;
  } frame_cfg_t;

  // one result beat
  typedef struct packed {
    logic [MV_W-1:0]  cell_mv;
    logic             frame_done;
    logic [MV_W-1:0]  max_mv;
    logic [POS_W-1:0] max_index;
    logic [MV_W-1:0]  min_mv;
    logic [POS_W-1:0] min_index;
    logic [SUM_W-1:0] sum_mv;
    logic             ov_trip;
    logic             uv_trip;
  } result_t;

endpackage

### rtl/cell_voltage_protection_monitor.sv
// Cell voltage protection monitor.
// Input channel: one beat per cell, a 14-bit ADC code, in cell order through
// a frame of 15 cells. Output channel: one beat per input beat with the cell
// voltage in millivolts; on the last cell of a frame it also carries the
// frame maximum and minimum with their first indices and the frame sum.
// The overvoltage and undervoltage trip flags come with every beat.
// Configuration: write cfg_we with cfg_index and cfg_wdata while the block is
// idle; indexes above five are dropped.
// Pipeline: three register stages (product, reciprocal divide, output);
// out_valid rises once a result is loaded into the output register.
// Throughput: one beat per cycle unless a stalled result freezes the
// pipeline; the code times gain product and the divide by 1000 each
// take a pipeline stage.
// Reset: frame position, running max and sum and the event counters clear,
// the running min sets to all ones, the pipeline empties and the registers load their default values.
// Stall: while out_stall holds a waiting result the whole pipeline freezes
// and in_stall is raised; it drops in the cycle the result is taken.
module cell_voltage_protection_monitor (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [cvpm_pkg::CODE_W-1:0]            in_raw_code,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [cvpm_pkg::MV_W-1:0]              out_cell_mv,
  output logic                                   out_frame_done,
  output logic [cvpm_pkg::MV_W-1:0]              out_max_mv,
  output logic [cvpm_pkg::POS_W-1:0]             out_max_index,
  output logic [cvpm_pkg::MV_W-1:0]              out_min_mv,
  output logic [cvpm_pkg::POS_W-1:0]             out_min_index,
  output logic [cvpm_pkg::SUM_W-1:0]             out_sum_mv,
  output logic                                   out_ov_trip,
  output logic                                   out_uv_trip,
  input  logic                                   cfg_we,
  input  logic [cvpm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cvpm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  logic [cvpm_pkg::GAIN_W-1:0]        gain_r;
  logic signed [cvpm_pkg::OFS_W-1:0]  offset_r;
  cvpm_pkg::frame_cfg_t               fcfg_r;
  logic                               adv;
  logic                               mv_valid;
  logic [cvpm_pkg::MV_W-1:0]          mv;
  cvpm_pkg::result_t                  result;

  // pipeline moves unless a result sits stalled at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r           <= cvpm_pkg::GAIN_RST;
      offset_r         <= cvpm_pkg::OFFSET_RST;
      fcfg_r.ov_thresh <= cvpm_pkg::OV_THRESH_RST;
      fcfg_r.uv_thresh <= cvpm_pkg::UV_THRESH_RST;
      fcfg_r.ov_limit  <= cvpm_pkg::OV_LIMIT_RST;
      fcfg_r.uv_limit  <= cvpm_pkg::UV_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cvpm_pkg::REG_ADC_GAIN:   gain_r           <= cfg_wdata[cvpm_pkg::GAIN_W-1:0];
        cvpm_pkg::REG_ADC_OFFSET: offset_r         <= $signed(cfg_wdata[cvpm_pkg::OFS_W-1:0]);
        cvpm_pkg::REG_OV_THRESH:  fcfg_r.ov_thresh <= cfg_wdata[cvpm_pkg::MV_W-1:0];
        cvpm_pkg::REG_UV_THRESH:  fcfg_r.uv_thresh <= cfg_wdata[cvpm_pkg::MV_W-1:0];
        cvpm_pkg::REG_OV_LIMIT:   fcfg_r.ov_limit  <= cfg_wdata[cvpm_pkg::EVT_W-1:0];
        cvpm_pkg::REG_UV_LIMIT:   fcfg_r.uv_limit  <= cfg_wdata[cvpm_pkg::EVT_W-1:0];
        default: ;
      endcase
    end
  end

  // code to millivolts
  cvpm_convert u_convert (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_code  (in_raw_code),
    .gain     (gain_r),
    .offset   (offset_r),
    .mv_valid (mv_valid),
    .mv       (mv)
  );

  // frame statistics and protection counters
  cvpm_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .mv_valid  (mv_valid),
    .mv        (mv),
    .cfg       (fcfg_r),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_cell_mv    = result.cell_mv;
  assign out_frame_done = result.frame_done;
  assign out_max_mv     = result.max_mv;
  assign out_max_index  = result.max_index;
  assign out_min_mv     = result.min_mv;
  assign out_min_index  = result.min_index;
  assign out_sum_mv     = result.sum_mv;
  assign out_ov_trip    = result.ov_trip;
  assign out_uv_trip    = result.uv_trip;

endmodule

### rtl/cvpm_convert.sv
module cvpm_convert (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic [cvpm_pkg::CODE_W-1:0]           in_code,
  input  logic [cvpm_pkg::GAIN_W-1:0]           gain,
  input  logic signed [cvpm_pkg::OFS_W-1:0]     offset,
  output logic                                  mv_valid,
  output logic [cvpm_pkg::MV_W-1:0]             mv
);

  logic                              prod_valid_r;
  logic [cvpm_pkg::PROD_W-1:0]       product_r;
  logic [cvpm_pkg::PROD_W-1:0]       product_nxt;
  logic [cvpm_pkg::SCALED_W-1:0]     scaled;
  logic [cvpm_pkg::QUOT_W-1:0]       quot;
  logic signed [cvpm_pkg::MV_W:0]    shifted;
  logic                              mv_valid_r;
  logic [cvpm_pkg::MV_W-1:0]         mv_r;
  logic [cvpm_pkg::MV_W-1:0]         mv_nxt;

  // code times gain in microvolts
  assign product_nxt = cvpm_pkg::PROD_W'(in_code) * cvpm_pkg::PROD_W'(gain);

  // divide by 1000 through the reciprocal, then add the offset
  assign scaled  = cvpm_pkg::SCALED_W'(product_r) * cvpm_pkg::SCALED_W'(cvpm_pkg::RECIP);
  assign quot    = scaled[cvpm_pkg::RECIP_SHIFT +: cvpm_pkg::QUOT_W];
  assign shifted = $signed({{(cvpm_pkg::MV_W + 1 - cvpm_pkg::QUOT_W){1'b0}}, quot})
                 + (cvpm_pkg::MV_W + 1)'(offset);

  // clamp below at zero; the top bit is the sign
  always_comb begin
    if (shifted[cvpm_pkg::MV_W]) begin
      mv_nxt = '0;
    end else begin
      mv_nxt = shifted[cvpm_pkg::MV_W-1:0];
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      mv_valid_r   <= 1'b0;
    end else if (adv) begin
      prod_valid_r <= in_valid;
      mv_valid_r   <= prod_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      product_r <= product_nxt;
      mv_r      <= mv_nxt;
    end
  end

  assign mv_valid = mv_valid_r;
  assign mv       = mv_r;

endmodule

### rtl/cvpm_frame.sv
module cvpm_frame (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         mv_valid,
  input  logic [cvpm_pkg::MV_W-1:0]    mv,
  input  cvpm_pkg::frame_cfg_t         cfg,
  output logic                         out_valid,
  output cvpm_pkg::result_t            result
);

  logic [cvpm_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [cvpm_pkg::MV_W-1:0]   max_r, max_nxt;
  logic [cvpm_pkg::POS_W-1:0]  max_pos_r, max_pos_nxt;
  logic [cvpm_pkg::MV_W-1:0]   min_r, min_nxt;
  logic [cvpm_pkg::POS_W-1:0]  min_pos_r, min_pos_nxt;
  logic [cvpm_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [cvpm_pkg::SUM_W:0]    sum_wide;
  logic [cvpm_pkg::EVT_W-1:0]  ov_evt_r, ov_evt_nxt;
  logic [cvpm_pkg::EVT_W-1:0]  uv_evt_r, uv_evt_nxt;
  logic                        last;
  logic                        valid_r;
  cvpm_pkg::result_t           result_r, result_nxt;

  assign last     = (pos_r >= cvpm_pkg::LAST_POS);
  assign sum_wide = {1'b0, sum_r} + (cvpm_pkg::SUM_W + 1)'(mv);

  // running max, min and sum
  always_comb begin
    max_nxt     = max_r;
    max_pos_nxt = max_pos_r;
    min_nxt     = min_r;
    min_pos_nxt = min_pos_r;
    if (pos_r == '0) begin
      max_nxt     = mv;
      max_pos_nxt = '0;
      min_nxt     = mv;
      min_pos_nxt = '0;
      sum_nxt     = cvpm_pkg::SUM_W'(mv);
    end else begin
      if (mv > max_r) begin
        max_nxt     = mv;
        max_pos_nxt = pos_r;
      end
      if (mv < min_r) begin
        min_nxt     = mv;
        min_pos_nxt = pos_r;
      end
      if (sum_wide[cvpm_pkg::SUM_W]) begin
        sum_nxt = cvpm_pkg::SUM_MAX;
      end else begin
        sum_nxt = sum_wide[cvpm_pkg::SUM_W-1:0];
      end
    end
  end

  // cell position; at the end of a frame it wraps and the event counters update
  always_comb begin
    ov_evt_nxt = ov_evt_r;
    uv_evt_nxt = uv_evt_r;
    pos_nxt    = pos_r + 1'b1;
    if (last) begin
      pos_nxt = '0;
      if (max_nxt > cfg.ov_thresh && ov_evt_r != cvpm_pkg::EVENT_MAX) begin
        ov_evt_nxt = ov_evt_r + 1'b1;
      end
      if (min_nxt < cfg.uv_thresh && uv_evt_r != cvpm_pkg::EVENT_MAX) begin
        uv_evt_nxt = uv_evt_r + 1'b1;
      end
    end
  end

  // result beat; frame fields read zero except on the last cell
  always_comb begin
    result_nxt            = '0;
    result_nxt.cell_mv    = mv;
    result_nxt.ov_trip    = (ov_evt_nxt >= cfg.ov_limit);
    result_nxt.uv_trip    = (uv_evt_nxt >= cfg.uv_limit);
    if (last) begin
      result_nxt.frame_done = 1'b1;
      result_nxt.max_mv     = max_nxt;
      result_nxt.max_index  = max_pos_nxt;
      result_nxt.min_mv     = min_nxt;
      result_nxt.min_index  = min_pos_nxt;
      result_nxt.sum_mv     = sum_nxt;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      max_r     <= '0;
      max_pos_r <= '0;
      min_r     <= cvpm_pkg::MV_MAX;
      min_pos_r <= '0;
      sum_r     <= '0;
      ov_evt_r  <= '0;
      uv_evt_r  <= '0;
    end else if (adv && mv_valid) begin
      pos_r     <= pos_nxt;
      max_r     <= max_nxt;
      max_pos_r <= max_pos_nxt;
      min_r     <= min_nxt;
      min_pos_r <= min_pos_nxt;
      sum_r     <= sum_nxt;
      ov_evt_r  <= ov_evt_nxt;
      uv_evt_r  <= uv_evt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= mv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && mv_valid) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = valid_r;
  assign result    = result_r;

endmodule
